/* hdl/u8det_pkg.sv */
// -----------------------------------------------------------------------------
// u8det_pkg
// Shared types, byte constants and class codes for the UTF-8 / ASCII
// encoding detector.
// -----------------------------------------------------------------------------
package u8det_pkg;

   typedef logic [1:0] class_type;

   localparam class_type CLASS_ASCII    = 2'd0;
   localparam class_type CLASS_UTF8     = 2'd1;
   localparam class_type CLASS_UTF8_BOM = 2'd2;
   localparam class_type CLASS_CODEPAGE = 2'd3;

   localparam logic [7:0] BOM_BYTE0     = 8'hEF;
   localparam logic [7:0] BOM_BYTE1     = 8'hBB;
   localparam logic [7:0] BOM_BYTE2     = 8'hBF;
   localparam logic [7:0] CONT_MASK     = 8'hC0;
   localparam logic [7:0] CONT_TAG      = 8'h80;
   localparam logic [7:0] LEAD2_LOW     = 8'hC0;
   localparam logic [7:0] LEAD3_LOW     = 8'hE0;
   localparam logic [7:0] LEAD4_LOW     = 8'hF0;
   localparam logic [7:0] LEAD2_PAYLOAD = 8'h1F;
   localparam logic [7:0] LEAD3_PAYLOAD = 8'h0F;

   localparam logic [1:0] BOM_LEN = 2'd3;

   // one request as it leaves the input register
   typedef struct packed {
      logic       take;
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       last;
   } step_type;

   typedef struct packed {
      logic       scan_stopped;
      logic       ascii_only;
      logic       utf8_ok;
      logic [1:0] continuations_left;
      logic       pending_fault;
      logic [1:0] byte_position;
      logic       bom_match;
   } scan_state_type;

   localparam scan_state_type SCAN_RESET = '{
      scan_stopped:       1'b0,
      ascii_only:         1'b1,
      utf8_ok:            1'b1,
      continuations_left: 2'd0,
      pending_fault:      1'b0,
      byte_position:      2'd0,
      bom_match:          1'b1
   };

   function automatic logic [7:0] bom_byte(input logic [1:0] pos);
      logic [7:0] b;
      case (pos)
         2'd0: b = BOM_BYTE0;
         2'd1: b = BOM_BYTE1;
         2'd2: b = BOM_BYTE2;
         default: b = BOM_BYTE2;
      endcase
      return b;
   endfunction

endpackage

/* hdl/u8det_if.sv */
// -----------------------------------------------------------------------------
// u8det request and response channels
// Valid/ready channels carrying file bytes in and the encoding class out.
// -----------------------------------------------------------------------------
interface u8det_req_if;
   import u8det_pkg::*;

   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_valid;
   logic       last;

   modport source (output valid, output data_byte, output byte_valid, output last,
                   input ready);
   modport sink   (input valid, input data_byte, input byte_valid, input last,
                   output ready);
endinterface

interface u8det_rsp_if;
   import u8det_pkg::*;

   logic      valid;
   logic      ready;
   class_type encoding_class;

   modport source (output valid, output encoding_class, input ready);
   modport sink   (input valid, input encoding_class, output ready);
endinterface

/* hdl/u8det_scan.sv */
// -----------------------------------------------------------------------------
// u8det_scan
// Running scan state and per-byte update; gives the class of the file as it
// stands after the current request.
// -----------------------------------------------------------------------------
module u8det_scan (
   input  logic                  clock,
   input  logic                  reset,
   input  u8det_pkg::step_type   step,
   output u8det_pkg::class_type  encoding_class
);
   import u8det_pkg::*;

   scan_state_type st_ff;
   scan_state_type st_in;
   scan_state_type nx;
   logic [7:0]     b;
   logic           pend;

   always_comb begin
      nx   = st_ff;
      b    = step.data_byte;
      pend = st_ff.pending_fault | ((b & CONT_MASK) != CONT_TAG);
      if (step.byte_valid) begin
         if (st_ff.byte_position != BOM_LEN) begin
            if (b != bom_byte(st_ff.byte_position)) begin
               nx.bom_match = 1'b0;
            end
            nx.byte_position = st_ff.byte_position + 2'd1;
         end
         if (!st_ff.scan_stopped) begin
            if (st_ff.continuations_left != 2'd0) begin
               nx.pending_fault      = pend;
               nx.continuations_left = st_ff.continuations_left - 2'd1;
               // fault is committed on the final byte of the sequence
               if (st_ff.continuations_left == 2'd1 && pend) begin
                  nx.utf8_ok      = 1'b0;
                  nx.scan_stopped = 1'b1;
               end
            end else if (b == 8'd0 || (b >= CONT_TAG && b < LEAD2_LOW) || b >= LEAD4_LOW) begin
               nx.ascii_only   = 1'b0;
               nx.utf8_ok      = 1'b0;
               nx.scan_stopped = 1'b1;
            end else if (b >= LEAD2_LOW && b < LEAD3_LOW) begin
               nx.ascii_only         = 1'b0;
               nx.continuations_left = 2'd1;
               nx.pending_fault      = ((b & LEAD2_PAYLOAD) == 8'd0);
            end else if (b >= LEAD3_LOW) begin
               nx.ascii_only         = 1'b0;
               nx.continuations_left = 2'd2;
               nx.pending_fault      = ((b & LEAD3_PAYLOAD) == 8'd0);
            end
         end
      end

      if (nx.byte_position == BOM_LEN && nx.bom_match) begin
         encoding_class = CLASS_UTF8_BOM;
      end else if (nx.ascii_only) begin
         encoding_class = CLASS_ASCII;
      end else if (nx.utf8_ok) begin
         encoding_class = CLASS_UTF8;
      end else begin
         encoding_class = CLASS_CODEPAGE;
      end

      if (!step.take) begin
         st_in = st_ff;
      end else if (step.last) begin
         st_in = SCAN_RESET;
      end else begin
         st_in = nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= SCAN_RESET;
      end else begin
         st_ff <= st_in;
      end
   end

endmodule

/* hdl/utf8_ascii_encoding_detector_unit.sv */
// -----------------------------------------------------------------------------
// utf8_ascii_encoding_detector_unit
// Classifies a byte stream as 7-bit ASCII, UTF-8, UTF-8 with BOM or codepage.
//
//   channel  dir  payload                           accepted when
//   req      in   data_byte, byte_valid, last       req.valid && req.ready
//   rsp      out  encoding_class (one per last)     rsp.valid && rsp.ready
//
// one byte per cycle sustained while no class waits untaken; a request goes
// through the input register and the scan update, and a last request shows
// its class on rsp from the output register, where it waits until taken.
// reset is synchronous and returns the scan to an empty file.
// requests that are not last never wait in the input register; a last request
// waits there only while a class is still untaken, and holds back req meanwhile.
// -----------------------------------------------------------------------------
module utf8_ascii_encoding_detector_unit (
   input  logic         clock,
   input  logic         reset,
   u8det_req_if.sink    req,
   u8det_rsp_if.source  rsp
);
   import u8det_pkg::*;

   logic       s1_valid_ff;
   logic       s1_valid_in;
   logic [7:0] s1_byte_ff;
   logic       s1_byte_valid_ff;
   logic       s1_last_ff;
   logic       s1_advance;
   logic       out_valid_ff;
   logic       out_valid_in;
   class_type  out_class_ff;
   class_type  scan_class;
   step_type   step;

   // only a last request needs the output register
   assign s1_advance = s1_valid_ff && (!s1_last_ff || !out_valid_ff || rsp.ready);
   assign req.ready  = !s1_valid_ff || s1_advance;

   assign step.take       = s1_advance;
   assign step.data_byte  = s1_byte_ff;
   assign step.byte_valid = s1_byte_valid_ff;
   assign step.last       = s1_last_ff;

   u8det_scan u_scan (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .encoding_class (scan_class)
   );

   always_comb begin
      s1_valid_in  = req.valid || (s1_valid_ff && !s1_advance);
      out_valid_in = out_valid_ff && !rsp.ready;
      if (s1_advance && s1_last_ff) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         s1_byte_ff       <= req.data_byte;
         s1_byte_valid_ff <= req.byte_valid;
         s1_last_ff       <= req.last;
      end
      if (s1_advance && s1_last_ff) begin
         out_class_ff <= scan_class;
      end
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.encoding_class = out_class_ff;

endmodule

/* hdl/u8det_checker.sv */
// -----------------------------------------------------------------------------
// u8det_checker
// Port-level checks on the encoding detector, bound to the top level.
// -----------------------------------------------------------------------------
module u8det_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  req_last,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input u8det_pkg::class_type  rsp_encoding_class
);
   import u8det_pkg::*;

   // a stalled response stays up
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_encoding_class))
      else $error("response class changed while stalled");

   // a fresh response comes from a last request accepted through the input register
   a_rsp_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_last, 2))
      else $error("response without a matching last request");

   // requests are only held back by an untaken response
   a_ready_backpressure : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request stalled without response back-pressure");

endmodule

bind utf8_ascii_encoding_detector_unit u8det_checker u_u8det_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req.valid),
   .req_ready          (req.ready),
   .req_last           (req.last),
   .rsp_valid          (rsp.valid),
   .rsp_ready          (rsp.ready),
   .rsp_encoding_class (rsp.encoding_class)
);
